// ----- hw/rtl/utf8gs_pkg.sv -----
package utf8gs_pkg;

  // code point width and fixed output widths
  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned TOTAL_W = 32;

  // special code points
  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] ZWJ_CP  = 21'h00200D;
  localparam logic [CP_W-1:0] CR_CP   = 21'h00000D;
  localparam logic [CP_W-1:0] LF_CP   = 21'h00000A;

  // regional indicators
  localparam logic [CP_W-1:0] RI_LO = 21'h01F1E6;
  localparam logic [CP_W-1:0] RI_HI = 21'h01F1FF;

  // precomposed hangul syllables
  localparam logic [CP_W-1:0] HANGUL_LO = 21'h00AC00;
  localparam logic [CP_W-1:0] HANGUL_HI = 21'h00D7A3;

  // reciprocal of the trailing consonant count (28), exact for offsets below 11172
  localparam logic [15:0] HANGUL_DIV_MUL   = 16'd37450;
  localparam int unsigned HANGUL_DIV_SHIFT = 20;

  // extend ranges
  localparam int unsigned NUM_EXT = 19;
  localparam logic [CP_W-1:0] EXT_LO [NUM_EXT] = '{
    21'h000300, 21'h000483, 21'h000591, 21'h0005BF, 21'h0005C1, 21'h000610,
    21'h00064B, 21'h000670, 21'h0006D6, 21'h000900, 21'h00093A, 21'h000981,
    21'h001AB0, 21'h001DC0, 21'h0020D0, 21'h00FE00, 21'h00FE20, 21'h0E0100,
    21'h01F3FB
  };
  localparam logic [CP_W-1:0] EXT_HI [NUM_EXT] = '{
    21'h00036F, 21'h000489, 21'h0005BD, 21'h0005BF, 21'h0005C2, 21'h00061A,
    21'h00065F, 21'h000670, 21'h0006ED, 21'h000903, 21'h00094F, 21'h000983,
    21'h001AFF, 21'h001DFF, 21'h0020FF, 21'h00FE0F, 21'h00FE2F, 21'h0E01EF,
    21'h01F3FF
  };

  // grapheme class of a code point
  typedef enum logic [3:0] {
    CL_NONE  = 4'd0,
    CL_OTHER = 4'd1,
    CL_CR    = 4'd2,
    CL_ZWJ   = 4'd3,
    CL_L     = 4'd4,
    CL_V     = 4'd5,
    CL_T     = 4'd6,
    CL_LV    = 4'd7,
    CL_LVT   = 4'd8,
    CL_RI    = 4'd9
  } gcls_t;

  // work left by one input byte: replacement results first, then an optional tail
  typedef struct packed {
    logic [1:0]       repl_count;
    logic             tail_valid;
    logic [CP_W-1:0]  tail_cp;
    logic [LEN_W-1:0] tail_len;
    logic             eot;
  } plan_t;

  // one emission toward the segmenter
  typedef struct packed {
    logic            fire;
    logic            flush;
    logic [CP_W-1:0] cp;
  } seg_req_t;

  // segmenter answer for the current emission
  typedef struct packed {
    logic               start;
    logic [TOTAL_W-1:0] total;
  } seg_res_t;

  function automatic logic in_range(logic [CP_W-1:0] v, logic [CP_W-1:0] lo,
                                    logic [CP_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic is_extend(logic [CP_W-1:0] v);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_EXT; i++) begin
      if (in_range(v, EXT_LO[i], EXT_HI[i])) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic gcls_t classify(logic [CP_W-1:0] v);
    logic [13:0] off;
    logic [29:0] prod;
    logic [9:0]  q;
    logic [14:0] q28;
    gcls_t       cls;
    off  = 14'(v - HANGUL_LO);
    prod = 30'(off) * 30'(HANGUL_DIV_MUL);
    q    = prod[29:HANGUL_DIV_SHIFT];
    // q * 28 as 32q - 4q
    q28  = 15'({q, 5'b0}) - 15'({q, 2'b0});
    if (v == CR_CP) cls = CL_CR;
    else if (v == ZWJ_CP) cls = CL_ZWJ;
    else if (in_range(v, RI_LO, RI_HI)) cls = CL_RI;
    else if (in_range(v, 21'h001100, 21'h00115F) || in_range(v, 21'h00A960, 21'h00A97C))
      cls = CL_L;
    else if (in_range(v, 21'h001160, 21'h0011A7) || in_range(v, 21'h00D7B0, 21'h00D7C6))
      cls = CL_V;
    else if (in_range(v, 21'h0011A8, 21'h0011FF) || in_range(v, 21'h00D7CB, 21'h00D7FB))
      cls = CL_T;
    else if (in_range(v, HANGUL_LO, HANGUL_HI))
      cls = (15'(off) == q28) ? CL_LV : CL_LVT;
    else cls = CL_OTHER;
    return cls;
  endfunction

  // no boundary between left and right
  function automatic logic glue(gcls_t left, gcls_t right, logic [CP_W-1:0] v);
    logic g;
    g = 1'b0;
    if (left == CL_CR && v == LF_CP) g = 1'b1;
    if (is_extend(v) || v == ZWJ_CP) g = 1'b1;
    if (left == CL_L && (right == CL_L || right == CL_V || right == CL_LV ||
                         right == CL_LVT)) g = 1'b1;
    if ((left == CL_LV || left == CL_V) && (right == CL_V || right == CL_T)) g = 1'b1;
    if ((left == CL_LVT || left == CL_T) && right == CL_T) g = 1'b1;
    if (left == CL_ZWJ) g = 1'b1;
    return g;
  endfunction

endpackage

// ----- hw/rtl/utf8gs_decode.sv -----
module utf8gs_decode (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_text,
  output utf8gs_pkg::plan_t       plan_next
);

  logic [2:0]                  exp_len;
  logic [1:0]                  taken;
  logic [utf8gs_pkg::CP_W-1:0] partial;

  logic [2:0]                  exp_len_next;
  logic [1:0]                  taken_next;
  logic [utf8gs_pkg::CP_W-1:0] partial_next;

  logic                        is_cont;
  logic [2:0]                  lead_len;
  logic [utf8gs_pkg::CP_W-1:0] lead_val;
  logic [utf8gs_pkg::CP_W-1:0] shifted;

  // lead byte decode
  always_comb begin
    lead_len = 3'd0;
    lead_val = '0;
    if (data_byte inside {[8'hC0:8'hDF]}) begin
      lead_len = 3'd2;
      lead_val = utf8gs_pkg::CP_W'(data_byte[4:0]);
    end else if (data_byte inside {[8'hE0:8'hEF]}) begin
      lead_len = 3'd3;
      lead_val = utf8gs_pkg::CP_W'(data_byte[3:0]);
    end else if (data_byte inside {[8'hF0:8'hF7]}) begin
      lead_len = 3'd4;
      lead_val = utf8gs_pkg::CP_W'(data_byte[2:0]);
    end
  end

  assign is_cont = (data_byte[7:6] == 2'b10);
  assign shifted = {partial[utf8gs_pkg::CP_W-7:0], data_byte[5:0]};

  // plan for this byte and next decoder state
  always_comb begin
    exp_len_next         = exp_len;
    taken_next           = taken;
    partial_next         = partial;
    plan_next.repl_count = 2'd0;
    plan_next.tail_valid = 1'b0;
    plan_next.tail_cp    = utf8gs_pkg::CP_W'(data_byte);
    plan_next.tail_len   = 3'd1;
    plan_next.eot        = end_of_text;

    if (exp_len != 3'd0 && is_cont) begin
      if (({1'b0, taken} + 3'd1) >= exp_len) begin
        // sequence complete
        plan_next.tail_valid = 1'b1;
        plan_next.tail_cp    = shifted;
        plan_next.tail_len   = exp_len;
        exp_len_next         = 3'd0;
        taken_next           = 2'd0;
        partial_next         = '0;
      end else begin
        taken_next   = taken + 2'd1;
        partial_next = shifted;
        // cut at end of text: lead and every taken byte are replaced
        if (end_of_text) plan_next.repl_count = taken + 2'd1;
      end
    end else begin
      // broken sequence: lead and taken continuations are replaced
      if (exp_len != 3'd0) plan_next.repl_count = taken;
      exp_len_next = 3'd0;
      taken_next   = 2'd0;
      partial_next = '0;
      if (!data_byte[7]) begin
        plan_next.tail_valid = 1'b1;
      end else if (lead_len != 3'd0 && !end_of_text) begin
        exp_len_next = lead_len;
        taken_next   = 2'd1;
        partial_next = lead_val;
      end else begin
        plan_next.tail_valid = 1'b1;
        plan_next.tail_cp    = utf8gs_pkg::REPL_CP;
      end
    end

    if (end_of_text) begin
      exp_len_next = 3'd0;
      taken_next   = 2'd0;
      partial_next = '0;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= 3'd0;
      taken   <= 2'd0;
      partial <= '0;
    end else if (accept) begin
      exp_len <= exp_len_next;
      taken   <= taken_next;
      partial <= partial_next;
    end
  end

endmodule

// ----- hw/rtl/utf8gs_segment.sv -----
module utf8gs_segment #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  utf8gs_pkg::seg_req_t req,
  output utf8gs_pkg::seg_res_t res
);

  utf8gs_pkg::gcls_t      prev_class;
  logic                   ri_parity;
  logic [COUNT_WIDTH-1:0] count;
  logic                   at_start;

  utf8gs_pkg::gcls_t      cls;
  logic                   start;
  logic                   ri_parity_next;
  logic [COUNT_WIDTH-1:0] count_next;

  // boundary decision for the current code point
  always_comb begin
    cls            = utf8gs_pkg::classify(req.cp);
    ri_parity_next = ri_parity;
    if (at_start) begin
      start = 1'b1;
    end else if (prev_class == utf8gs_pkg::CL_RI && cls == utf8gs_pkg::CL_RI) begin
      start = !ri_parity;
      if (ri_parity) ri_parity_next = 1'b0;
    end else begin
      start = !utf8gs_pkg::glue(prev_class, cls, req.cp);
    end
    count_next = count;
    if (start) begin
      ri_parity_next = (cls == utf8gs_pkg::CL_RI);
      if (count != {COUNT_WIDTH{1'b1}}) count_next = count + 1'b1;
    end
  end

  assign res.start = start;
  assign res.total = utf8gs_pkg::TOTAL_W'(count_next);

  // segmentation state, cleared after the last result of a text
  always_ff @(posedge clk) begin
    if (rst || req.flush) begin
      prev_class <= utf8gs_pkg::CL_NONE;
      ri_parity  <= 1'b0;
      count      <= '0;
      at_start   <= 1'b1;
    end else if (req.fire) begin
      prev_class <= cls;
      ri_parity  <= ri_parity_next;
      count      <= count_next;
      at_start   <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/utf8_grapheme_segmenter_top.sv -----
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------------
// input    | in_valid, in_stall  | data_byte, end_of_text
// output   | out_valid, out_stall| code_point, byte_length, starts_cluster,
//          |                     | cluster_total, last_of_run
//
// A byte is decoded into the plan register at its transfer; its results are then loaded one by
// one from the plan register into the result register, from which they transfer.
// One result is issued per cycle unless out_stall holds the result register, so a byte holds
// the plan register until its k results have issued (k up to 4 on a broken sequence).
// in_stall is high while the plan register owes more than this cycle's result or its last
// result is held by out_stall; rst is synchronous and clears decoder, segmenter and valids.
module utf8_grapheme_segmenter_top #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic [2:0]  byte_length,
  output logic        starts_cluster,
  output logic [31:0] cluster_total,
  output logic        last_of_run
);

  utf8gs_pkg::plan_t           plan_next;
  utf8gs_pkg::seg_req_t        seg_req;
  utf8gs_pkg::seg_res_t        seg_res;

  logic                        plan_valid;
  logic [1:0]                  rep_left;
  logic                        tail_left;
  logic [utf8gs_pkg::CP_W-1:0] plan_cp;
  logic [2:0]                  plan_len;
  logic                        plan_eot;

  logic                        accept;
  logic                        has_item;
  logic                        out_free;
  logic                        fire;
  logic                        emit_repl;
  logic                        last_emit;
  logic                        plan_done;
  logic [utf8gs_pkg::CP_W-1:0] emit_cp;

  utf8gs_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .plan_next   (plan_next)
  );

  // emission control
  assign has_item  = (rep_left != 2'd0) || tail_left;
  assign out_free  = !out_valid || !out_stall;
  assign fire      = plan_valid && has_item && out_free;
  assign emit_repl = (rep_left != 2'd0);
  assign last_emit = emit_repl ? (rep_left == 2'd1 && !tail_left) : 1'b1;
  assign plan_done = plan_valid && (!has_item || (fire && last_emit));
  assign in_stall  = plan_valid && !plan_done;
  assign accept    = in_valid && !in_stall;
  assign emit_cp   = emit_repl ? utf8gs_pkg::REPL_CP : plan_cp;

  assign seg_req.fire  = fire;
  assign seg_req.flush = plan_done && plan_eot;
  assign seg_req.cp    = emit_cp;

  utf8gs_segment #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_segment (
    .clk (clk),
    .rst (rst),
    .req (seg_req),
    .res (seg_res)
  );

  // plan register
  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
    end else if (accept) begin
      plan_valid <= 1'b1;
    end else if (plan_done) begin
      plan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rep_left  <= plan_next.repl_count;
      tail_left <= plan_next.tail_valid;
      plan_cp   <= plan_next.tail_cp;
      plan_len  <= plan_next.tail_len;
      plan_eot  <= plan_next.eot;
    end else if (fire) begin
      if (emit_repl) rep_left <= rep_left - 2'd1;
      else tail_left <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      code_point     <= emit_cp;
      byte_length    <= emit_repl ? 3'd1 : plan_len;
      starts_cluster <= seg_res.start;
      cluster_total  <= seg_res.total;
      last_of_run    <= last_emit;
    end
  end

  // a taken byte always lands in the plan register
  assert property (@(posedge clk) disable iff (rst) accept |=> plan_valid)
    else $error("plan register not loaded after input transfer");

  // no new byte while replacements and a tail are still owed
  assert property (@(posedge clk) disable iff (rst)
    (plan_valid && rep_left != 2'd0 && tail_left) |-> in_stall)
    else $error("input taken with results still pending");

  // a non-final emission keeps the input held
  assert property (@(posedge clk) disable iff (rst) (fire && !last_emit) |-> in_stall)
    else $error("input taken before last result of a byte");

endmodule
